/* rtl/pgseg_pkg.sv */
// Shared types, codes, constants and the CORDIC angle table of the polar grid ground segmenter.
package pgseg_pkg;

  localparam logic [1:0] KIND_INSERT   = 2'd0;
  localparam logic [1:0] KIND_CLASSIFY = 2'd1;
  localparam logic [1:0] KIND_CLEAR    = 2'd2;
  localparam logic [1:0] KIND_NONE     = 2'd3;

  localparam logic [1:0] CFG_SPREAD_LIMIT = 2'd0;
  localparam logic [1:0] CFG_MIN_RADIUS   = 2'd1;
  localparam logic [1:0] CFG_MAX_RADIUS   = 2'd2;
  localparam logic [1:0] CFG_RING_SCALE   = 2'd3;

  localparam logic [9:0]  RST_SPREAD_LIMIT = 10'd51;
  localparam logic [13:0] RST_MIN_RADIUS   = 14'd128;
  localparam logic [14:0] RST_MAX_RADIUS   = 15'd12800;
  localparam logic [15:0] RST_RING_SCALE   = 16'd827;

  localparam logic signed [15:0] EMPTY_MIN = 16'sd32767;
  localparam logic signed [15:0] EMPTY_MAX = -16'sd5120;

  // Number of steps of the shift-subtract square root on a 32-bit value.
  localparam int SQRT_STEPS = 16;

  typedef enum logic [3:0] {
    ST_INIT,
    ST_IDLE,
    ST_CLEAR,
    ST_SQUARE,
    ST_SUM,
    ST_RANGE,
    ST_ITER,
    ST_SCALE,
    ST_CLAMP,
    ST_ADDR,
    ST_READ,
    ST_UPDATE
  } state_t;

  typedef struct packed {
    logic load;
    logic square;
    logic sum;
    logic cordic_init;
    logic step;
    logic scale;
    logic clamp;
    logic addr;
    logic read;
    logic update;
    logic clr_write;
    logic post_zero;
    logic post_point;
    logic post_clear;
  } cmd_t;

  typedef struct packed {
    logic [1:0] kind;
    logic       in_range;
    logic       iter_last;
    logic       clr_last;
  } status_t;

  // Arctangent of 2^-i as a fraction of a full turn in 32-bit units.
  function automatic logic [31:0] atan_turn(input logic [4:0] i);
    logic [31:0] a;
    unique case (i)
      5'd0:  a = 32'h20000000;
      5'd1:  a = 32'h12E4051E;
      5'd2:  a = 32'h09FB385B;
      5'd3:  a = 32'h051111D4;
      5'd4:  a = 32'h028B0D43;
      5'd5:  a = 32'h0145D7E1;
      5'd6:  a = 32'h00A2F61E;
      5'd7:  a = 32'h00517C55;
      5'd8:  a = 32'h0028BE53;
      5'd9:  a = 32'h00145F2F;
      5'd10: a = 32'h000A2F98;
      5'd11: a = 32'h000517CC;
      5'd12: a = 32'h00028BE6;
      5'd13: a = 32'h000145F3;
      5'd14: a = 32'h0000A2FA;
      5'd15: a = 32'h0000517D;
      5'd16: a = 32'h000028BE;
      5'd17: a = 32'h0000145F;
      5'd18: a = 32'h00000A30;
      5'd19: a = 32'h00000518;
      5'd20: a = 32'h0000028C;
      5'd21: a = 32'h00000146;
      5'd22: a = 32'h000000A3;
      5'd23: a = 32'h00000051;
      default: a = 32'h00000000;
    endcase
    return a;
  endfunction

endpackage

/* rtl/polar_grid_ground_segmenter.sv */
// Top level of the polar grid ground segmenter: controller, datapath and checks.
//
// A point beat is taken when start is high and busy is low; each item gives
// exactly one result beat, marked by a one-cycle done strobe, which the
// receiver must take in that cycle, since it cannot stall the block. An insert
// or classify of an in-range point passes through squaring, summing and the
// range test, then the shared CORDIC and square root iteration for the larger
// of CORDIC_STEPS and SQRT_STEPS steps, then scaling, clamping, cell address,
// memory read and update; the result beat follows in the next cycle, and a new
// beat can be taken in that same cycle. An unused kind is answered from the
// squaring state and a point outside the radii from the range test. A clear
// writes one cell per cycle through the single memory write port, over all
// SECTORS*RINGS cells (28800 at the defaults); the same sweep runs once after
// reset, during which busy stays high.
// Configuration writes should only be made while no beat is in flight. The
// result fields hold their value until the next done.
module polar_grid_ground_segmenter
  import pgseg_pkg::*;
#(
  parameter int SECTORS      = 180,
  parameter int RINGS        = 160,
  parameter int CORDIC_STEPS = 16
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  logic [1:0]         kind,
  input  logic signed [15:0] x_pos,
  input  logic signed [15:0] y_pos,
  input  logic signed [15:0] z_height,
  input  logic               cfg_write,
  input  logic [1:0]         cfg_index,
  input  logic [15:0]        cfg_data,
  output logic               done,
  output logic               in_range,
  output logic               ground_flag,
  output logic [7:0]         sector,
  output logic [7:0]         ring,
  output logic               clear_done
);

  cmd_t    cmd;
  status_t stat;

  pgseg_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .stat  (stat),
    .cmd   (cmd),
    .busy  (busy),
    .done  (done)
  );

  pgseg_dp #(
    .SECTORS      (SECTORS),
    .RINGS        (RINGS),
    .CORDIC_STEPS (CORDIC_STEPS)
  ) u_dp (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .stat        (stat),
    .kind        (kind),
    .x_pos       (x_pos),
    .y_pos       (y_pos),
    .z_height    (z_height),
    .cfg_write   (cfg_write),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .in_range    (in_range),
    .ground_flag (ground_flag),
    .sector      (sector),
    .ring        (ring),
    .clear_done  (clear_done)
  );

  // An accepted beat always leaves idle, so the next cycle reports busy.
  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy)
    else $error("accepted beat did not make the block busy");

  // A result is never followed directly by another one.
  a_single_done: assert property (@(posedge clk) disable iff (rst)
    done |=> !done)
    else $error("two result beats in consecutive cycles");

  // A clear result carries no point information.
  a_clear_clean: assert property (@(posedge clk) disable iff (rst)
    (done && clear_done) |-> (!in_range && !ground_flag && sector == 8'd0 && ring == 8'd0))
    else $error("clear result carries point fields");

  // Only in-range points can be reported as ground.
  a_ground_range: assert property (@(posedge clk) disable iff (rst)
    (done && ground_flag) |-> in_range)
    else $error("ground reported for a point outside the radii");

endmodule

/* rtl/pgseg_ctrl.sv */
// Controller state machine that sequences the segmenter datapath.
module pgseg_ctrl
  import pgseg_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    start,
  input  status_t stat,
  output cmd_t    cmd,
  output logic    busy,
  output logic    done
);

  state_t state;
  state_t state_next;
  logic   done_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_INIT;
      done  <= 1'b0;
    end else begin
      state <= state_next;
      done  <= done_next;
    end
  end

  always_comb begin
    cmd        = '0;
    state_next = state;
    unique case (state)
      ST_INIT: begin
        cmd.clr_write = 1'b1;
        if (stat.clr_last) state_next = ST_IDLE;
      end
      ST_IDLE: begin
        if (start) begin
          cmd.load   = 1'b1;
          state_next = ST_SQUARE;
        end
      end
      ST_SQUARE: begin
        cmd.square = 1'b1;
        priority if (stat.kind == KIND_CLEAR) begin
          state_next = ST_CLEAR;
        end else if (stat.kind == KIND_NONE) begin
          cmd.post_zero = 1'b1;
          state_next    = ST_IDLE;
        end else begin
          state_next = ST_SUM;
        end
      end
      ST_SUM: begin
        cmd.sum    = 1'b1;
        state_next = ST_RANGE;
      end
      ST_RANGE: begin
        if (stat.in_range) begin
          cmd.cordic_init = 1'b1;
          state_next      = ST_ITER;
        end else begin
          cmd.post_zero = 1'b1;
          state_next    = ST_IDLE;
        end
      end
      ST_ITER: begin
        cmd.step = 1'b1;
        if (stat.iter_last) state_next = ST_SCALE;
      end
      ST_SCALE: begin
        cmd.scale  = 1'b1;
        state_next = ST_CLAMP;
      end
      ST_CLAMP: begin
        cmd.clamp  = 1'b1;
        state_next = ST_ADDR;
      end
      ST_ADDR: begin
        cmd.addr   = 1'b1;
        state_next = ST_READ;
      end
      ST_READ: begin
        cmd.read   = 1'b1;
        state_next = ST_UPDATE;
      end
      ST_UPDATE: begin
        cmd.update     = 1'b1;
        cmd.post_point = 1'b1;
        state_next     = ST_IDLE;
      end
      ST_CLEAR: begin
        cmd.clr_write = 1'b1;
        if (stat.clr_last) begin
          cmd.post_clear = 1'b1;
          state_next     = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  assign done_next = cmd.post_zero | cmd.post_point | cmd.post_clear;
  assign busy      = (state != ST_IDLE);

endmodule

/* rtl/pgseg_dp.sv */
// Datapath: range test, CORDIC angle, square root, cell addressing and the height memories.
module pgseg_dp
  import pgseg_pkg::*;
#(
  parameter int SECTORS      = 180,
  parameter int RINGS        = 160,
  parameter int CORDIC_STEPS = 16
) (
  input  logic               clk,
  input  logic               rst,
  input  cmd_t               cmd,
  output status_t            stat,
  input  logic [1:0]         kind,
  input  logic signed [15:0] x_pos,
  input  logic signed [15:0] y_pos,
  input  logic signed [15:0] z_height,
  input  logic               cfg_write,
  input  logic [1:0]         cfg_index,
  input  logic [15:0]        cfg_data,
  output logic               in_range,
  output logic               ground_flag,
  output logic [7:0]         sector,
  output logic [7:0]         ring,
  output logic               clear_done
);

  localparam int CELLS = SECTORS * RINGS;
  localparam int SW    = $clog2(SECTORS);
  localparam int RW    = $clog2(RINGS);
  localparam int CAW   = $clog2(CELLS);
  localparam int SPW   = $clog2(SECTORS + 1);
  localparam int PW    = 32 + SPW;
  localparam int ITERS = (CORDIC_STEPS > SQRT_STEPS) ? CORDIC_STEPS : SQRT_STEPS;
  localparam int CNTW  = $clog2(ITERS);
  localparam int CRW   = 27;

  logic [9:0]  spread_limit;
  logic [13:0] min_radius;
  logic [14:0] max_radius;
  logic [15:0] ring_scale;

  logic [1:0]         kind_q;
  logic signed [15:0] x_q, y_q, z_q;
  logic [30:0]        xsq, ysq;
  logic [27:0]        rmin2;
  logic [29:0]        rmax2;
  logic [31:0]        r2;

  logic signed [CRW-1:0] cx, cy;
  logic signed [CRW-1:0] cx0, cy0;
  logic [31:0]           cz;
  logic [31:0]           ang_w;
  logic [CNTW-1:0]       cnt;
  logic [31:0]           sv, sres, sbit, strial;

  logic [PW-1:0]  sprod;
  logic [31:0]    rprod;
  logic [15:0]    range_w;
  logic [SPW-1:0] sraw;
  logic [15:0]    rraw;
  logic [SW-1:0]  sector_q;
  logic [RW-1:0]  ring_q;
  logic [CAW-1:0] cell_addr;
  logic [CAW-1:0] clr_ptr;

  logic signed [15:0] mem_min [CELLS];
  logic signed [15:0] mem_max [CELLS];
  logic signed [15:0] rd_min, rd_max;
  logic signed [16:0] spread;
  logic               ground_calc;

  always_ff @(posedge clk) begin
    if (rst) begin
      spread_limit <= RST_SPREAD_LIMIT;
      min_radius   <= RST_MIN_RADIUS;
      max_radius   <= RST_MAX_RADIUS;
      ring_scale   <= RST_RING_SCALE;
    end else if (cfg_write) begin
      unique case (cfg_index)
        CFG_SPREAD_LIMIT: spread_limit <= cfg_data[9:0];
        CFG_MIN_RADIUS:   min_radius   <= cfg_data[13:0];
        CFG_MAX_RADIUS:   max_radius   <= cfg_data[14:0];
        CFG_RING_SCALE:   ring_scale   <= cfg_data;
        default:          ring_scale   <= ring_scale;
      endcase
    end
  end

  // Scaled start vector; it is folded into the right half plane when the iteration starts.
  assign cx0 = CRW'(x_q) <<< 8;
  assign cy0 = CRW'(y_q) <<< 8;

  assign sbit   = 32'd1 << (6'd30 - 6'({cnt, 1'b0}));
  assign strial = sres + sbit;
  assign range_w = sres[15:0];

  // Angle offset by half a turn, wrapping modulo a full turn.
  assign ang_w = cz + 32'h80000000;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      kind_q <= kind;
      x_q    <= x_pos;
      y_q    <= y_pos;
      z_q    <= z_height;
    end
    if (cmd.square) begin
      xsq   <= 31'(x_q * x_q);
      ysq   <= 31'(y_q * y_q);
      rmin2 <= 28'(min_radius) * 28'(min_radius);
      rmax2 <= 30'(max_radius) * 30'(max_radius);
    end
    if (cmd.sum) r2 <= {1'b0, xsq} + {1'b0, ysq};
    if (cmd.cordic_init) begin
      cnt  <= '0;
      sv   <= r2;
      sres <= '0;
      if (x_q < 0) begin
        cx <= -cx0;
        cy <= -cy0;
        cz <= 32'h80000000;
      end else begin
        cx <= cx0;
        cy <= cy0;
        cz <= 32'h00000000;
      end
    end
    if (cmd.step) begin
      cnt <= cnt + 1'b1;
      if (32'(cnt) < CORDIC_STEPS) begin
        if (cy > 0) begin
          cx <= cx + (cy >>> cnt);
          cy <= cy - (cx >>> cnt);
          cz <= cz + atan_turn(5'(cnt));
        end else begin
          cx <= cx - (cy >>> cnt);
          cy <= cy + (cx >>> cnt);
          cz <= cz - atan_turn(5'(cnt));
        end
      end
      if (32'(cnt) < SQRT_STEPS) begin
        if (sv >= strial) begin
          sv   <= sv - strial;
          sres <= (sres >> 1) + sbit;
        end else begin
          sres <= sres >> 1;
        end
      end
    end
    if (cmd.scale) begin
      sprod <= PW'(ang_w) * PW'(SECTORS);
      rprod <= (range_w > {2'b00, min_radius}) ?
               32'(range_w - {2'b00, min_radius}) * 32'(ring_scale) : 32'd0;
    end
    if (cmd.clamp) begin
      sector_q <= (32'(sraw) > SECTORS - 1) ? SW'(SECTORS - 1) : SW'(sraw);
      ring_q   <= (32'(rraw) > RINGS - 1) ? RW'(RINGS - 1) : RW'(rraw);
    end
    if (cmd.addr) cell_addr <= CAW'(32'(sector_q) * RINGS + 32'(ring_q));
  end

  assign sraw = sprod[32 +: SPW];
  assign rraw = rprod[31:16];

  // Height memories: one write port shared by the clear sweep and the insert update.
  always_ff @(posedge clk) begin
    if (cmd.clr_write) begin
      mem_min[clr_ptr] <= EMPTY_MIN;
      mem_max[clr_ptr] <= EMPTY_MAX;
    end else if (cmd.update && kind_q == KIND_INSERT) begin
      mem_min[cell_addr] <= (z_q < rd_min) ? z_q : rd_min;
      mem_max[cell_addr] <= (z_q > rd_max) ? z_q : rd_max;
    end
    if (cmd.read) begin
      rd_min <= mem_min[cell_addr];
      rd_max <= mem_max[cell_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_ptr <= '0;
    end else if (cmd.clr_write) begin
      clr_ptr <= stat.clr_last ? '0 : clr_ptr + 1'b1;
    end
  end

  assign spread      = 17'(rd_max) - 17'(rd_min);
  assign ground_calc = spread < $signed({7'b0, spread_limit});

  always_ff @(posedge clk) begin
    if (cmd.post_zero || cmd.post_clear) begin
      in_range    <= 1'b0;
      ground_flag <= 1'b0;
      sector      <= '0;
      ring        <= '0;
      clear_done  <= cmd.post_clear;
    end else if (cmd.post_point) begin
      in_range    <= 1'b1;
      ground_flag <= (kind_q == KIND_CLASSIFY) && ground_calc;
      sector      <= 8'(sector_q);
      ring        <= 8'(ring_q);
      clear_done  <= 1'b0;
    end
  end

  assign stat.kind      = kind_q;
  assign stat.in_range  = (r2 > {4'b0, rmin2}) && (r2 < {2'b0, rmax2});
  assign stat.iter_last = (32'(cnt) == ITERS - 1);
  assign stat.clr_last  = (32'(clr_ptr) == CELLS - 1);

endmodule
